// File: sv/bftr_pkg.sv
// Shared types and constants for the bitmap font text renderer.
package bftr_pkg;

    localparam int unsigned FONT_BYTES = 1024;
    localparam int unsigned FONT_AW    = 10;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CODE_W     = 7;
    localparam int unsigned POS_W      = 18;
    localparam int unsigned DIM_W      = 16;
    localparam int unsigned COLOUR_W   = 32;
    localparam int unsigned GLYPH_SIZE = 8;
    localparam int unsigned ROW_W      = 3;

    // queued operation
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_DRAW = 1'b1
    } t_op;

    // back end sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_back_state;

    // clipping window handed to the back end
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_raster;

endpackage

// File: sv/bftr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bftr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bftr_queue.sv
// Small register FIFO between the front and back ends.
module bftr_queue #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             push_ok, pop_ok;

    assign push_ok = i_push && (r_count != CW'(DEPTH));
    assign pop_ok  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

endmodule

// File: sv/bftr_front.sv
// Front end: accepts items, drops empty draws, tracks the text cursor.
module bftr_front #(
    parameter int unsigned COORD_BITS = 18,
    parameter int unsigned EW = 58 + 2 * 18
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_kind,
    input  logic [bftr_pkg::FONT_AW-1:0]      i_font_address,
    input  logic [bftr_pkg::BYTE_W-1:0]       i_font_data,
    input  logic [bftr_pkg::CODE_W-1:0]       i_char_code,
    input  logic                              i_start_text,
    input  logic signed [bftr_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [bftr_pkg::POS_W-1:0] i_pos_y,
    input  logic [bftr_pkg::COLOUR_W-1:0]     i_colour,
    input  logic                              i_q_full,
    output logic                              o_push,
    output logic [EW-1:0]                     o_push_data
);

    logic [COORD_BITS-1:0] r_cursor_x, n_cursor_x;
    logic [COORD_BITS-1:0] r_cursor_y, n_cursor_y;
    logic [COORD_BITS-1:0] org_x, org_y;
    logic                  accept, is_draw;
    bftr_pkg::t_op         op;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign op         = bftr_pkg::t_op'(i_kind);
    assign is_draw    = (op == bftr_pkg::OP_DRAW);

    // placed origin, or continue at the cursor
    assign org_x = i_start_text ? COORD_BITS'(i_pos_x) : r_cursor_x;
    assign org_y = i_start_text ? COORD_BITS'(i_pos_y) : r_cursor_y;

    // code zero is consumed here and never queued
    assign o_push = accept && (!is_draw || (i_char_code != '0));
    assign o_push_data = {i_kind, i_font_address, i_font_data, i_char_code,
                          org_x, org_y, i_colour};

    always_comb begin
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        if (o_push && is_draw) begin
            n_cursor_x = org_x + COORD_BITS'(bftr_pkg::GLYPH_SIZE);
            n_cursor_y = org_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_cursor_y <= '0;
        end else begin
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
        end
    end

endmodule

// File: sv/bftr_back.sv
// Back end: font writes, glyph row scan with clipping, pixel emission.
module bftr_back #(
    parameter int unsigned COORD_BITS = 18,
    parameter int unsigned EW = 58 + 2 * 18
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bftr_pkg::t_raster                i_raster,
    input  logic                             i_q_valid,
    input  logic [EW-1:0]                    i_q_data,
    output logic                             o_q_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bftr_pkg::DIM_W-1:0]       o_pixel_x,
    output logic [bftr_pkg::DIM_W-1:0]       o_pixel_y,
    output logic [bftr_pkg::COLOUR_W-1:0]    o_pixel_value,
    output logic                             o_last_pixel
);

    localparam int unsigned CW = (COORD_BITS + 1 > bftr_pkg::DIM_W + 1) ?
                                 COORD_BITS + 1 : bftr_pkg::DIM_W + 1;
    localparam int unsigned GS = bftr_pkg::GLYPH_SIZE;
    localparam int unsigned RW = bftr_pkg::ROW_W;

    // queue entry fields
    logic                          e_kind;
    logic [bftr_pkg::FONT_AW-1:0]  e_addr;
    logic [bftr_pkg::BYTE_W-1:0]   e_data;
    logic [bftr_pkg::CODE_W-1:0]   e_code;
    logic [COORD_BITS-1:0]         e_ox, e_oy;
    logic [bftr_pkg::COLOUR_W-1:0] e_colour;

    assign {e_kind, e_addr, e_data, e_code, e_ox, e_oy, e_colour} = i_q_data;

    bftr_pkg::t_back_state r_state, n_state;

    logic [RW:0]                   r_row, n_row;        // read issue row, 0..8
    logic                          r_rsp_vld;
    logic [RW-1:0]                 r_rsp_row;
    logic [RW-1:0]                 r_erow, n_erow;
    logic [bftr_pkg::CODE_W-1:0]   r_code;
    logic [COORD_BITS-1:0]         r_ox, r_oy;
    logic [bftr_pkg::COLOUR_W-1:0] r_colour;
    logic [GS-1:0]                 r_mask [GS];

    logic                          r_out_vld;
    logic [bftr_pkg::DIM_W-1:0]    r_px, r_py;
    logic [bftr_pkg::COLOUR_W-1:0] r_pval;
    logic                          r_plast;

    logic                          ram_we, ram_re;
    logic [bftr_pkg::FONT_AW-1:0]  ram_raddr;
    logic [bftr_pkg::BYTE_W-1:0]   ram_rdata;

    logic                          out_free, emit, take_draw, row_ok, later_any;
    logic [GS-1:0]                 vis_mask, cur, rest;
    logic [RW-1:0]                 col;
    logic signed [CW-1:0]          ox_e, oy_e, py_scan, px_emit, py_emit;
    logic [CW-1:0]                 width_e, height_e;

    bftr_ram #(
        .WIDTH (bftr_pkg::BYTE_W),
        .DEPTH (bftr_pkg::FONT_BYTES)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (e_addr),
        .i_wdata (e_data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ox_e     = CW'($signed(r_ox));
    assign oy_e     = CW'($signed(r_oy));
    assign width_e  = CW'(i_raster.width);
    assign height_e = CW'(i_raster.height);
    assign out_free = !r_out_vld || i_out_ready;

    // glyph byte address: {code row, glyph row, code column}
    assign ram_raddr = {r_code[bftr_pkg::CODE_W-1:4], r_row[RW-1:0], r_code[3:0]};

    // clip mask of the row whose font byte just came back
    always_comb begin
        logic signed [CW-1:0] px;
        py_scan = oy_e + CW'(r_rsp_row);
        row_ok  = !py_scan[CW-1] && (py_scan < height_e);
        for (int c = 0; c < GS; c++) begin
            px = ox_e + CW'(c);
            vis_mask[c] = ram_rdata[c] && row_ok && !px[CW-1] && (px < width_e);
        end
    end

    // lowest pending column of the current row, and lookahead for last
    always_comb begin
        cur = r_mask[r_erow];
        col = '0;
        for (int c = GS - 1; c >= 0; c--) begin
            if (cur[c]) begin
                col = RW'(c);
            end
        end
        rest = cur & ~(GS'(1) << col);
        later_any = 1'b0;
        for (int j = 0; j < GS; j++) begin
            if ((RW'(j) > r_erow) && (r_mask[j] != '0)) begin
                later_any = 1'b1;
            end
        end
        px_emit = ox_e + CW'(col);
        py_emit = oy_e + CW'(r_erow);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bftr_pkg::ST_IDLE: begin
                if (i_q_valid && (bftr_pkg::t_op'(e_kind) == bftr_pkg::OP_DRAW)) begin
                    n_state = bftr_pkg::ST_SCAN;
                end
            end
            bftr_pkg::ST_SCAN: begin
                if (r_rsp_vld && (r_rsp_row == RW'(GS - 1))) begin
                    n_state = bftr_pkg::ST_EMIT;
                end
            end
            bftr_pkg::ST_EMIT: begin
                if ((r_erow == RW'(GS - 1)) && ((cur == '0) || (out_free && rest == '0))) begin
                    n_state = bftr_pkg::ST_IDLE;
                end
            end
            default: n_state = bftr_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_q_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        take_draw = 1'b0;
        emit      = 1'b0;
        n_row     = r_row;
        n_erow    = r_erow;
        unique case (r_state)
            bftr_pkg::ST_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    ram_we    = (bftr_pkg::t_op'(e_kind) == bftr_pkg::OP_LOAD);
                    take_draw = !ram_we;
                end
                n_row  = '0;
                n_erow = '0;
            end
            bftr_pkg::ST_SCAN: begin
                ram_re = !r_row[RW];
                if (!r_row[RW]) begin
                    n_row = r_row + 1'b1;
                end
            end
            bftr_pkg::ST_EMIT: begin
                if (cur == '0) begin
                    n_erow = r_erow + 1'b1;
                end else if (out_free) begin
                    emit = 1'b1;
                    if (rest == '0) begin
                        n_erow = r_erow + 1'b1;
                    end
                end
            end
            default: begin
                n_row = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bftr_pkg::ST_IDLE;
            r_rsp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rsp_vld <= ram_re;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row     <= n_row;
        r_erow    <= n_erow;
        r_rsp_row <= r_row[RW-1:0];
        if (take_draw) begin
            r_code   <= e_code;
            r_ox     <= e_ox;
            r_oy     <= e_oy;
            r_colour <= e_colour;
        end
        if (r_rsp_vld) begin
            r_mask[r_rsp_row] <= vis_mask;
        end else if (emit) begin
            r_mask[r_erow] <= rest;
        end
        if (emit) begin
            r_px    <= px_emit[bftr_pkg::DIM_W-1:0];
            r_py    <= py_emit[bftr_pkg::DIM_W-1:0];
            r_pval  <= r_colour;
            r_plast <= (rest == '0) && !later_any;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_value = r_pval;
    assign o_last_pixel  = r_plast;

endmodule

// File: sv/bitmap_font_text_renderer.sv
// Bitmap font text renderer: 8x8 glyphs from a loadable font to clipped pixel writes.
//
// Input channel (i_in_valid / o_in_ready): one transfer is either a font byte
// load (i_kind 0) or a character draw (i_kind 1). The font is 128 pixels wide,
// 16 glyphs per row, bit 0 of a byte is the leftmost pixel. Draws with code 0
// are consumed without effect. Output channel (o_out_valid / i_out_ready): one
// transfer per visible set glyph bit, rows top to bottom, columns left to
// right; o_last_pixel marks the final write of a character.
// Config: APB, raster_width at 0x0, raster_height at 0x4 (both reset 1024).
// Timing: the front end takes an item while the two-entry queue has room.
// A load is written to the font RAM as the back end dequeues it. A draw is
// dequeued, then its 8 font rows are read from the font RAM (one read port,
// one row per cycle) and clipped, then its visible pixels are emitted in
// order, each row without visible pixels taking a step of its own. The back
// end renders one character at a time while further items wait in the queue.
// Reset clears the cursor, the queue and the sequencer; the font RAM is not
// cleared and must be loaded before use. If the receiver stalls, the output
// register holds its pixel, the back end waits, and the queue then fills.
module bitmap_font_text_renderer #(
    parameter int unsigned COORD_BITS = 18
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // input items
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_kind,
    input  logic [bftr_pkg::FONT_AW-1:0]      i_font_address,
    input  logic [bftr_pkg::BYTE_W-1:0]       i_font_data,
    input  logic [bftr_pkg::CODE_W-1:0]       i_char_code,
    input  logic                              i_start_text,
    input  logic signed [bftr_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [bftr_pkg::POS_W-1:0] i_pos_y,
    input  logic [bftr_pkg::COLOUR_W-1:0]     i_colour,
    // pixel writes
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [bftr_pkg::DIM_W-1:0]        o_pixel_x,
    output logic [bftr_pkg::DIM_W-1:0]        o_pixel_y,
    output logic [bftr_pkg::COLOUR_W-1:0]     o_pixel_value,
    output logic                              o_last_pixel
);

    // queue entry: kind, address, data, code, origin x/y, colour
    localparam int unsigned EW = 1 + bftr_pkg::FONT_AW + bftr_pkg::BYTE_W +
                                 bftr_pkg::CODE_W + 2 * COORD_BITS + bftr_pkg::COLOUR_W;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [bftr_pkg::DIM_W-1:0] r_raster_width;
    logic [bftr_pkg::DIM_W-1:0] r_raster_height;
    logic                       cfg_wr;
    bftr_pkg::t_raster          raster;

    logic          q_push, q_full, q_pop, q_valid;
    logic [EW-1:0] q_push_data, q_data;

    // register file: index is address bit 2
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raster_width  <= bftr_pkg::DIM_W'(1024);
            r_raster_height <= bftr_pkg::DIM_W'(1024);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_WIDTH:  r_raster_width  <= pwdata[bftr_pkg::DIM_W-1:0];
                REG_HEIGHT: r_raster_height <= pwdata[bftr_pkg::DIM_W-1:0];
                default:    r_raster_width  <= r_raster_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = 32'(r_raster_width);
            REG_HEIGHT: prdata = 32'(r_raster_height);
            default:    prdata = '0;
        endcase
    end

    assign raster.width  = r_raster_width;
    assign raster.height = r_raster_height;

    // front end: accept, classify, resolve glyph origin
    bftr_front #(
        .COORD_BITS (COORD_BITS),
        .EW         (EW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_font_address (i_font_address),
        .i_font_data    (i_font_data),
        .i_char_code    (i_char_code),
        .i_start_text   (i_start_text),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_colour       (i_colour),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_push_data    (q_push_data)
    );

    // decoupling queue
    bftr_queue #(
        .WIDTH (EW),
        .DEPTH (2)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    // back end: font RAM, row scan, pixel emission
    bftr_back #(
        .COORD_BITS (COORD_BITS),
        .EW         (EW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_raster      (raster),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_value (o_pixel_value),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

// File: sim/tb_bitmap_font_text_renderer.sv
// Self-checking testbench for the bitmap font text renderer.
`timescale 1ns / 100ps

module tb_bitmap_font_text_renderer;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 150;   // worst case: queue of two plus one glyph in flight
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the input queue
    localparam int MAX_REPORTS  = 60;

    // register indexes on the APB port
    localparam int REG_RASTER_WIDTH  = 0;
    localparam int REG_RASTER_HEIGHT = 1;

    typedef struct {
        bftr_pkg::t_op                      kind;
        logic [bftr_pkg::FONT_AW-1:0]       addr;
        logic [bftr_pkg::BYTE_W-1:0]        data;
        logic [bftr_pkg::CODE_W-1:0]        code;
        logic                               start;
        logic signed [bftr_pkg::POS_W-1:0]  px;
        logic signed [bftr_pkg::POS_W-1:0]  py;
        logic [bftr_pkg::COLOUR_W-1:0]      colour;
    } t_item;

    typedef struct packed {
        logic [bftr_pkg::DIM_W-1:0]    x;
        logic [bftr_pkg::DIM_W-1:0]    y;
        logic [bftr_pkg::COLOUR_W-1:0] value;
        logic                          last;
    } t_pixel;

    // ---------------------------------------------------------------
    // Block ports: every input starts at a known value
    // ---------------------------------------------------------------
    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [2:0]                        paddr = '0;
    logic [31:0]                       pwdata = '0;
    logic [31:0]                       prdata;
    logic                              pready;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    logic                              i_kind = 1'b0;
    logic [bftr_pkg::FONT_AW-1:0]      i_font_address = '0;
    logic [bftr_pkg::BYTE_W-1:0]       i_font_data = '0;
    logic [bftr_pkg::CODE_W-1:0]       i_char_code = '0;
    logic                              i_start_text = 1'b0;
    logic signed [bftr_pkg::POS_W-1:0] i_pos_x = '0;
    logic signed [bftr_pkg::POS_W-1:0] i_pos_y = '0;
    logic [bftr_pkg::COLOUR_W-1:0]     i_colour = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic [bftr_pkg::DIM_W-1:0]        o_pixel_x;
    logic [bftr_pkg::DIM_W-1:0]        o_pixel_y;
    logic [bftr_pkg::COLOUR_W-1:0]     o_pixel_value;
    logic                              o_last_pixel;

    bitmap_font_text_renderer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_font_address (i_font_address),
        .i_font_data    (i_font_data),
        .i_char_code    (i_char_code),
        .i_start_text   (i_start_text),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_colour       (i_colour),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_value  (o_pixel_value),
        .o_last_pixel   (o_last_pixel)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Testbench state
    // ---------------------------------------------------------------
    t_item            render_items[$];     // items waiting for the driver
    t_pixel           pixel_writes[$];     // predicted pixel writes, oldest first
    t_item            offered;             // item currently on the input port
    bit               in_taken = 1'b0;     // offered item went in at the last rising edge
    bit               calm = 1'b0;         // final stretch: no idling on either side
    int               send_gap = 0;
    int               rx_stall = 0;
    int               hold_left = 0;
    int               mismatches = 0;
    int               cycle_count = 0;

    // predictor copy of the block state
    logic [bftr_pkg::BYTE_W-1:0] font_mem [0:bftr_pkg::FONT_BYTES-1];
    logic [bftr_pkg::POS_W-1:0]  cur_x = '0;
    logic [bftr_pkg::POS_W-1:0]  cur_y = '0;
    logic [bftr_pkg::DIM_W-1:0]  raster_w = 16'd1024;
    logic [bftr_pkg::DIM_W-1:0]  raster_h = 16'd1024;

    // font bytes already queued for loading; draws only use fully loaded glyphs
    bit [bftr_pkg::FONT_BYTES-1:0] font_set = '0;

    task automatic flag_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // Predictor: one accepted item -> its pixel writes
    // ---------------------------------------------------------------
    task automatic render_item(input t_item it);
        t_pixel                      held;
        bit                          have_held;
        int                          sx, sy, px, py, row, col;
        logic [bftr_pkg::BYTE_W-1:0] bits;
        have_held = 1'b0;
        held = '0;
        if (it.kind == bftr_pkg::OP_LOAD) begin
            font_mem[it.addr] = it.data;
        end else if (it.code != '0) begin
            if (it.start) begin
                cur_x = it.px;
                cur_y = it.py;
            end
            sx = int'($signed(cur_x));
            sy = int'($signed(cur_y));
            for (row = 0; row < int'(bftr_pkg::GLYPH_SIZE); row++) begin
                // glyph rows sit 16 bytes apart; code picks column and band
                bits = font_mem[{it.code[6:4], 3'(row), it.code[3:0]}];
                py = sy + row;
                for (col = 0; col < int'(bftr_pkg::GLYPH_SIZE); col++) begin
                    px = sx + col;
                    if (bits[col] && px >= 0 && py >= 0 &&
                        px < int'(raster_w) && py < int'(raster_h)) begin
                        // hold one back so the final write can carry last
                        if (have_held)
                            pixel_writes.push_back(held);
                        held.x = px[bftr_pkg::DIM_W-1:0];
                        held.y = py[bftr_pkg::DIM_W-1:0];
                        held.value = it.colour;
                        held.last = 1'b0;
                        have_held = 1'b1;
                    end
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                pixel_writes.push_back(held);
            end
            // cursor moves on even when every pixel was clipped
            cur_x = cur_x + bftr_pkg::POS_W'(bftr_pkg::GLYPH_SIZE);
        end
    endtask

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    function automatic t_item random_fields();
        t_item it;
        it.kind = bftr_pkg::OP_DRAW;
        it.addr = bftr_pkg::FONT_AW'($urandom);
        it.data = bftr_pkg::BYTE_W'($urandom);
        it.code = bftr_pkg::CODE_W'($urandom);
        it.start = 1'($urandom);
        it.px = bftr_pkg::POS_W'($urandom);
        it.py = bftr_pkg::POS_W'($urandom);
        it.colour = $urandom;
        return it;
    endfunction

    task automatic queue_load(input logic [bftr_pkg::FONT_AW-1:0] addr,
                              input logic [bftr_pkg::BYTE_W-1:0] data);
        t_item it;
        it = random_fields();
        it.kind = bftr_pkg::OP_LOAD;
        it.addr = addr;
        it.data = data;
        font_set[addr] = 1'b1;
        render_items.push_back(it);
    endtask

    // bitmap row r sits in bits [8r+7:8r]
    task automatic queue_glyph(input logic [bftr_pkg::CODE_W-1:0] code, input logic [63:0] bitmap);
        int r;
        for (r = 0; r < int'(bftr_pkg::GLYPH_SIZE); r++)
            queue_load({code[6:4], 3'(r), code[3:0]}, bitmap[8*r +: 8]);
    endtask

    task automatic queue_draw(input logic [bftr_pkg::CODE_W-1:0] code, input logic start,
                              input int x, input int y,
                              input logic [bftr_pkg::COLOUR_W-1:0] colour);
        t_item it;
        it = random_fields();
        it.code = code;
        it.start = start;
        it.px = x[bftr_pkg::POS_W-1:0];
        it.py = y[bftr_pkg::POS_W-1:0];
        it.colour = colour;
        render_items.push_back(it);
    endtask

    function automatic bit glyph_loaded(input logic [bftr_pkg::CODE_W-1:0] code);
        int r;
        for (r = 0; r < int'(bftr_pkg::GLYPH_SIZE); r++)
            if (!font_set[{code[6:4], 3'(r), code[3:0]}])
                return 1'b0;
        return 1'b1;
    endfunction

    // Mostly draws of loaded glyphs with random placement; some glyph
    // loads, stray font bytes and code-zero draws mixed in.
    task automatic queue_random_items(input int count, input int pos_lo, input int pos_span);
        int                          added, pick, vx, vy;
        logic [bftr_pkg::CODE_W-1:0] code;
        t_item                       zero_item;
        added = 0;
        while (added < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                code = bftr_pkg::CODE_W'($urandom_range(1, 127));
                queue_glyph(code, {$urandom, $urandom});
                added += int'(bftr_pkg::GLYPH_SIZE);
            end else if (pick < 13) begin
                queue_load(bftr_pkg::FONT_AW'($urandom), bftr_pkg::BYTE_W'($urandom));
                added++;
            end else if (pick < 20) begin
                // code zero: everything else random, nothing may change
                zero_item = random_fields();
                zero_item.code = '0;
                render_items.push_back(zero_item);
                added++;
            end else begin
                code = bftr_pkg::CODE_W'($urandom_range(1, 127));
                while (!glyph_loaded(code))
                    code = bftr_pkg::CODE_W'($urandom_range(1, 127));
                if (pick < 28) begin
                    vx = $urandom;
                    vy = $urandom;
                end else begin
                    vx = pos_lo + int'($urandom_range(0, pos_span));
                    vy = pos_lo + int'($urandom_range(0, pos_span));
                end
                queue_draw(code, 1'($urandom_range(0, 1)), vx, vy, $urandom);
                added++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // APB: setup cycle then access cycle, driven on falling edges
    // ---------------------------------------------------------------
    task automatic apb_access(input bit write, input int idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = write;
        paddr = 3'(4 * idx);
        pwdata = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic check_raster_regs();
        logic [31:0] got;
        apb_access(1'b0, REG_RASTER_WIDTH, '0, got);
        if (got !== {16'h0, raster_w})
            flag_mismatch($sformatf("raster_width reads %0h, want %0h", got, raster_w));
        apb_access(1'b0, REG_RASTER_HEIGHT, '0, got);
        if (got !== {16'h0, raster_h})
            flag_mismatch($sformatf("raster_height reads %0h, want %0h", got, raster_h));
    endtask

    // upper data bits are junk: only the low 16 land in the register
    task automatic set_raster(input logic [bftr_pkg::DIM_W-1:0] w,
                              input logic [bftr_pkg::DIM_W-1:0] h);
        logic [31:0] unused;
        logic [15:0] junk;
        junk = 16'($urandom);
        apb_access(1'b1, REG_RASTER_WIDTH, {junk, w}, unused);
        junk = 16'($urandom);
        apb_access(1'b1, REG_RASTER_HEIGHT, {junk, h}, unused);
        raster_w = w;
        raster_h = h;
        check_raster_regs();
    endtask

    // Block is idle once every item went in, every write came out, and
    // items without writes have had time to leave the pipeline.
    task automatic drain();
        while (render_items.size() != 0 || i_in_valid || pixel_writes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Input driver: new item on the falling edge after a transfer
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            in_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (render_items.size() != 0) begin
                offered = render_items.pop_front();
                i_kind <= offered.kind;
                i_font_address <= offered.addr;
                i_font_data <= offered.data;
                i_char_code <= offered.code;
                i_start_text <= offered.start;
                i_pos_x <= offered.px;
                i_pos_y <= offered.py;
                i_colour <= offered.colour;
                i_in_valid <= 1'b1;
                // idle burst after this item is taken
                if (!calm && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(1, 13);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // input transfer: predict its writes at the edge it is accepted
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            render_item(offered);
            in_taken = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stall bursts, plus the long hold-off
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            rx_stall = $urandom_range(1, 13) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // ---------------------------------------------------------------
    // Monitor: each output transfer against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : watch_pixels
        t_pixel want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pixel_writes.size() == 0) begin
                flag_mismatch($sformatf("write (%0d,%0d) with none pending",
                                        o_pixel_x, o_pixel_y));
            end else begin
                want = pixel_writes.pop_front();
                if (o_pixel_x !== want.x)
                    flag_mismatch($sformatf("pixel_x %0d, want %0d", o_pixel_x, want.x));
                if (o_pixel_y !== want.y)
                    flag_mismatch($sformatf("pixel_y %0d, want %0d", o_pixel_y, want.y));
                if (o_pixel_value !== want.value)
                    flag_mismatch($sformatf("pixel_value %0h, want %0h",
                                            o_pixel_value, want.value));
                if (o_last_pixel !== want.last)
                    flag_mismatch($sformatf("last_pixel %0b, want %0b at (%0d,%0d)",
                                            o_last_pixel, want.last, want.x, want.y));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence of phases
    // ---------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values of both registers
        check_raster_regs();

        // directed: full glyph at 127 gives the 64-write worst case
        queue_glyph(7'h7F, {64{1'b1}});
        queue_load('0, '0);                             // lowest address, zero byte
        queue_draw(7'h7F, 1'b1, 0, 0, 32'hFFFF_FFFF);   // all 64 visible
        queue_draw(7'h7F, 1'b0, 77, 77, 32'h1234_5678); // continues at x=8
        queue_draw(7'h00, 1'b1, 500, 500, 32'hDEAD_BEEF); // code zero: cursor kept
        queue_draw(7'h7F, 1'b0, 0, 0, 32'h0F0F_0F0F);   // so this lands at x=16
        queue_draw(7'h7F, 1'b1, -4, -4, 32'h0000_0000); // clipped on negative side
        queue_draw(7'h7F, 1'b1, 1020, 1020, 32'hA5A5_5A5A); // clipped past the raster
        queue_draw(7'h7F, 1'b1, -16, 100, 32'h0000_0001);   // all clipped
        queue_draw(7'h7F, 1'b0, 0, 0, 32'h0000_0002);   // at -8: all clipped again
        queue_draw(7'h7F, 1'b0, 0, 0, 32'h0000_0003);   // cursor reached x=0: visible
        queue_draw(7'h7F, 1'b1, -131072, -131072, 32'h8000_0000); // most negative
        queue_draw(7'h7F, 1'b1, 131064, 131071, 32'h7FFF_FFFF);   // near most positive
        queue_draw(7'h7F, 1'b0, 0, 0, 32'h5555_AAAA);   // cursor wraps to negative
        drain();

        // smallest raster: only pixel (0,0) survives
        set_raster(16'd1, 16'd1);
        queue_random_items(30, -7, 7);
        drain();

        // largest raster, glyphs near its far edge; receiver holds off
        // first so the input queue backs up
        set_raster(16'hFFFF, 16'hFFFF);
        @(posedge i_clk);
        hold_left <= HOLD_CYCLES;
        queue_random_items(50, 65500, 40);
        drain();

        // zero width drops everything
        set_raster(16'd0, 16'hFFFF);
        queue_random_items(12, -4, 40);
        drain();

        set_raster(16'($urandom_range(8, 300)), 16'($urandom_range(8, 300)));
        queue_random_items(50, -10, 300);
        drain();

        // last stretch runs without idling
        calm = 1'b1;
        set_raster(16'd640, 16'd480);
        queue_random_items(50, -10, 650);
        drain();

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/bftr_pkg.sv
sv/bftr_ram.sv
sv/bftr_queue.sv
sv/bftr_front.sv
sv/bftr_back.sv
sv/bitmap_font_text_renderer.sv
sim/tb_bitmap_font_text_renderer.sv
